@@ rtl/cubic_bezier_bounding_box_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier bounding box block
// Concurrent checks are clocked on clk and switched off while rst is high.
// When SYNTH is defined the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_BOUNDING_BOX_MACROS_SVH
`define CUBIC_BEZIER_BOUNDING_BOX_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define CBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The condition must never be true outside reset.
`define CBB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CBB_ASSERT(lbl, prop, msg)
`define CBB_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier bounding box package
// Widths, stage records and per-stage step functions of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

  localparam int CW     = 32;          // coordinate width, Q16.16
  localparam int T_FRAC = 30;          // fraction bits of the curve parameter
  localparam int DW     = CW + 1;      // difference of two coordinates
  localparam int TLW    = CW + 2;      // linear term of the derivative
  localparam int DENW   = CW + 3;      // quadratic term of the derivative
  localparam int PRW    = 2 * DW;      // product of two differences
  localparam int DISCW  = PRW + 1;     // signed discriminant
  localparam int SQ_N   = CW + 1;      // root bits, one per square root stage
  localparam int RADW   = 2 * SQ_N;    // radicand bits
  localparam int SQRW   = SQ_N + 2;    // square root partial remainder
  localparam int NUMW   = CW + 4;      // signed root numerator
  localparam int DDW    = DENW;        // divisor magnitude
  localparam int DVRW   = DDW + 1;     // divider partial remainder
  localparam int TW     = T_FRAC + 1;  // curve parameter, unsigned Q1.30
  localparam int PW     = DW + TW + 1; // lerp product
  localparam int NPT    = 4;           // control points
  localparam int NAX    = 2;           // axes
  localparam int NRT    = 2 * NAX;     // roots, two per axis

  typedef logic signed [CW-1:0] coord_t;

  // Control points of one axis and the box of the end points.
  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
    coord_t lo;
    coord_t hi;
  } axis_ctx_t;

  typedef struct packed {
    logic                   skip;
    logic signed [DENW-1:0] den;
    logic signed [TLW-1:0]  tl;
    logic [SQRW-1:0]        rem;
    logic [SQ_N-1:0]        root;
    logic [RADW-1:0]        rad;
  } sqrt_t;

  typedef struct packed {
    logic              ok;
    logic              one;
    logic [DDW-1:0]    dd;
    logic [DVRW-1:0]   rem;
    logic [T_FRAC-1:0] q;
  } div_t;

  typedef struct packed {
    logic                   ok;
    logic [TW-1:0]          t;
    coord_t [NPT-1:0]       v;
    logic [NPT-2:0][PW-1:0] pd;
  } lerp_t;

  // One bit of the integer square root, two radicand bits consumed.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t           n;
    logic [SQRW+1:0] acc;
    logic [SQRW+1:0] trial;
    n     = s;
    acc   = {s.rem, s.rad[RADW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    if (acc >= trial) begin
      n.rem  = SQRW'(acc - trial);
      n.root = {s.root[SQ_N-2:0], 1'b1};
    end else begin
      n.rem  = acc[SQRW-1:0];
      n.root = {s.root[SQ_N-2:0], 1'b0};
    end
    n.rad = {s.rad[RADW-3:0], 2'b00};
    return n;
  endfunction

  // One quotient bit of the restoring division num / dd.
  function automatic div_t div_step(div_t s);
    div_t            n;
    logic [DVRW-1:0] sh;
    logic [DVRW-1:0] ddx;
    n   = s;
    sh  = {s.rem[DVRW-2:0], 1'b0};
    ddx = {1'b0, s.dd};
    if (sh >= ddx) begin
      n.rem = sh - ddx;
      n.q   = {s.q[T_FRAC-2:0], 1'b1};
    end else begin
      n.rem = sh;
      n.q   = {s.q[T_FRAC-2:0], 1'b0};
    end
    return n;
  endfunction

  // Products (v[j+1] - v[j]) * t of one de Casteljau level.
  function automatic lerp_t lerp_mul(lerp_t s);
    lerp_t                n;
    logic signed [DW-1:0] diff;
    logic signed [TW:0]   ts;
    logic signed [PW-1:0] prod;
    n  = s;
    ts = $signed({1'b0, s.t});
    for (int j = 0; j < NPT - 1; j++) begin
      diff    = DW'($signed(s.v[j+1])) - DW'($signed(s.v[j]));
      prod    = diff * ts;
      n.pd[j] = prod;
    end
    return n;
  endfunction

  // v[j] + floor(product / 2^T_FRAC); the result lies between the two points.
  function automatic lerp_t lerp_add(lerp_t s);
    lerp_t                n;
    logic signed [PW-1:0] sh;
    n = s;
    for (int j = 0; j < NPT - 1; j++) begin
      sh     = $signed(s.pd[j]) >>> T_FRAC;
      n.v[j] = s.v[j] + sh[CW-1:0];
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cubic_bezier_bounding_box.sv @@
// ----------------------------------------------------------------------------
// Cubic Bezier bounding box: a registered pipeline from input beat to output valid.
// Throughput one segment per cycle while the skid register is empty; no item waits on another.
// Reset clears the stage valid bits and the output buffer; data is kept.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_bounding_box_macros.svh"

// The block takes the four control points of a cubic Bezier segment and
// returns its tight axis-aligned bounding box. Both axes run side by side.
//
// Pipeline, one register stage each:
//   1      differences p, q, r of neighboring points, end point box
//   2      q*q and p*r, derivative terms den and tl
//   3      discriminant, skip flag when it is negative or den is zero
//   4..36  integer square root, one root bit per stage (33 stages)
//   37     both root numerators, sign fix and the range test 0 <= t <= 1
//   38..67 restoring divider, one bit of t per stage (30 stages)
//   68     t in Q1.30 and the control points loaded for evaluation
//   69..74 de Casteljau, a multiply stage and an add stage per level
//   75     output register, after the min and max merge
// The square root and the divider set the depth of the pipeline. The curve
// value always stays within the coordinate range, so saturation never
// changes a result and no clamp is built.
//
// Flow control: the whole pipeline advances unless the skid register holds
// a beat. The output register and the skid register together take the beat
// leaving the last stage while the consumer stalls, so no beat is lost.
module cubic_bezier_bounding_box (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y from the lowest bit up
  input  logic [8*cbb_pkg::CW-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // box_xmin, box_xmax, box_ymin, box_ymax from the lowest bit up
  output logic [4*cbb_pkg::CW-1:0]  m_tdata
);
  import cbb_pkg::*;

  localparam int LV_N = NPT - 1;
  localparam int DV_N = T_FRAC;
  localparam int S_D  = 3;
  localparam int S_N  = S_D + SQ_N + 1;
  localparam int S_T  = S_N + DV_N + 1;
  localparam int LAST = S_T + 2 * LV_N;

  logic en;
  logic incoming;
  logic [LAST:1] vld;

  coord_t    pt   [NAX][NPT];
  axis_ctx_t [NAX-1:0] ctx [1:LAST];

  logic signed [DW-1:0]    pv   [NAX];
  logic signed [DW-1:0]    qv   [NAX];
  logic signed [DW-1:0]    rv   [NAX];
  logic signed [PRW-1:0]   qq   [NAX];
  logic signed [PRW-1:0]   pr   [NAX];
  logic signed [DENW-1:0]  den2 [NAX];
  logic signed [TLW-1:0]   tl2  [NAX];
  logic signed [DISCW-1:0] disc [NAX];

  sqrt_t sq  [0:SQ_N][NAX];
  div_t  dv0 [NRT];
  div_t  dv  [0:DV_N][NRT];
  lerp_t lp0 [NRT];
  lerp_t lp  [0:2*LV_N][NRT];

  logic [4*CW-1:0] box;
  logic [4*CW-1:0] out_data;
  logic [4*CW-1:0] skid_data;
  logic            out_vld;
  logic            skid_vld;

  assign en       = !skid_vld;
  assign s_tready = en;
  assign incoming = vld[LAST] && en;

  // Unpack the input beat: point j of axis ax.
  always_comb begin
    for (int ax = 0; ax < NAX; ax++) begin
      for (int j = 0; j < NPT; j++) begin
        pt[ax][j] = s_tdata[(2*j+ax)*CW +: CW];
      end
    end
  end

  always_comb begin
    for (int ax = 0; ax < NAX; ax++) begin
      disc[ax] = DISCW'(qq[ax]) - DISCW'(pr[ax]);
    end
  end

  // Root numerators tl - s and tl + s, normalized to a positive divisor.
  always_comb begin
    for (int r = 0; r < NRT; r++) begin
      logic signed [NUMW-1:0] sx;
      logic signed [NUMW-1:0] tlx;
      logic signed [NUMW-1:0] num;
      logic signed [NUMW-1:0] numa;
      logic [NUMW-1:0]        numu;
      logic [DDW-1:0]         ddu;
      logic                   neg;
      sx   = $signed(NUMW'(sq[SQ_N][r>>1].root));
      tlx  = NUMW'(sq[SQ_N][r>>1].tl);
      num  = ((r & 1) != 0) ? tlx + sx : tlx - sx;
      neg  = sq[SQ_N][r>>1].den[DENW-1];
      ddu  = neg ? DDW'(-sq[SQ_N][r>>1].den) : DDW'(sq[SQ_N][r>>1].den);
      numa = neg ? -num : num;
      numu = numa;
      dv0[r].ok  = !sq[SQ_N][r>>1].skip && !numu[NUMW-1] && (numu <= {1'b0, ddu});
      dv0[r].one = (numu == {1'b0, ddu});
      dv0[r].dd  = ddu;
      dv0[r].rem = DVRW'(numu);
      dv0[r].q   = '0;
    end
  end

  // Curve parameter and the control points of the root's axis.
  always_comb begin
    for (int r = 0; r < NRT; r++) begin
      axis_ctx_t cx;
      cx        = ctx[S_T-1][r>>1];
      lp0[r].ok = dv[DV_N][r].ok;
      lp0[r].t  = dv[DV_N][r].one ? (TW'(1) << T_FRAC) : {1'b0, dv[DV_N][r].q};
      lp0[r].v  = {cx.d, cx.c, cx.b, cx.a};
      lp0[r].pd = '0;
    end
  end

  // Merge the end point box with the curve values at the valid roots.
  always_comb begin
    for (int ax = 0; ax < NAX; ax++) begin
      coord_t lo;
      coord_t hi;
      coord_t v;
      lo = ctx[LAST][ax].lo;
      hi = ctx[LAST][ax].hi;
      for (int k = 0; k < 2; k++) begin
        v = lp[2*LV_N][2*ax+k].v[0];
        if (lp[2*LV_N][2*ax+k].ok && (v < lo)) begin
          lo = v;
        end
        if (lp[2*LV_N][2*ax+k].ok && (v > hi)) begin
          hi = v;
        end
      end
      box[(2*ax)*CW +: CW]   = lo;
      box[(2*ax+1)*CW +: CW] = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < NAX; ax++) begin
        ctx[1][ax].a  <= pt[ax][0];
        ctx[1][ax].b  <= pt[ax][1];
        ctx[1][ax].c  <= pt[ax][2];
        ctx[1][ax].d  <= pt[ax][3];
        ctx[1][ax].lo <= (pt[ax][0] < pt[ax][3]) ? pt[ax][0] : pt[ax][3];
        ctx[1][ax].hi <= (pt[ax][0] < pt[ax][3]) ? pt[ax][3] : pt[ax][0];
        pv[ax] <= DW'(pt[ax][1]) - DW'(pt[ax][0]);
        qv[ax] <= DW'(pt[ax][2]) - DW'(pt[ax][1]);
        rv[ax] <= DW'(pt[ax][3]) - DW'(pt[ax][2]);

        qq[ax]   <= qv[ax] * qv[ax];
        pr[ax]   <= pv[ax] * rv[ax];
        den2[ax] <= DENW'(pv[ax]) - (DENW'(qv[ax]) <<< 1) + DENW'(rv[ax]);
        tl2[ax]  <= TLW'(pv[ax]) - TLW'(qv[ax]);

        sq[0][ax].skip <= (den2[ax] == '0) || disc[ax][DISCW-1];
        sq[0][ax].den  <= den2[ax];
        sq[0][ax].tl   <= tl2[ax];
        sq[0][ax].rem  <= '0;
        sq[0][ax].root <= '0;
        sq[0][ax].rad  <= disc[ax][RADW-1:0];
        for (int i = 1; i <= SQ_N; i++) begin
          sq[i][ax] <= sqrt_step(sq[i-1][ax]);
        end
      end
      for (int r = 0; r < NRT; r++) begin
        dv[0][r] <= dv0[r];
        for (int i = 1; i <= DV_N; i++) begin
          dv[i][r] <= div_step(dv[i-1][r]);
        end
        lp[0][r] <= lp0[r];
        for (int k = 1; k <= 2 * LV_N; k++) begin
          lp[k][r] <= ((k & 1) != 0) ? lerp_mul(lp[k-1][r]) : lerp_add(lp[k-1][r]);
        end
      end
      for (int i = 2; i <= LAST; i++) begin
        ctx[i] <= ctx[i-1];
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= incoming;
      end
    end else if (incoming) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_tready) begin
      out_data <= skid_vld ? skid_data : box;
    end else if (incoming) begin
      skid_data <= box;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  // The skid entry is only ever occupied behind a full output register.
  `CBB_NEVER(a_skid_behind_out, skid_vld && !out_vld, "skid holds a beat while output is empty")
  // The skid entry fills only when the consumer stalls a waiting result.
  `CBB_ASSERT(a_skid_fill, $rose(skid_vld) |-> $past(out_vld && !m_tready), "skid filled without a stall")
  // While the skid entry is occupied, no stage of the pipeline moves.
  `CBB_ASSERT(a_frozen, skid_vld |=> $stable(vld), "pipeline moved while the skid was full")
  // An accepted beat shows up as valid in the first stage.
  `CBB_ASSERT(a_enter, (s_tvalid && s_tready) |=> vld[1], "accepted beat lost at the first stage")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the cubic Bezier bounding box block
// Streams control point sets through the pipeline under varying back-pressure
// and compares every output box against the row's own box or an in-bench model of the box math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cbb_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, well past the depth
  localparam int DRAIN_WAIT  = 90;    // a little more than the pipeline depth
  localparam int STALL_LIMIT = 4000;  // cycles with no beat before giving up
  localparam int N_RANDOM    = 600;
  localparam int N_ROWS      = 12;

  typedef struct {
    coord_t pt[8];   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  } segment_t;

  typedef struct {
    coord_t xmin, xmax, ymin, ymax;
  } box_t;

  typedef struct {
    segment_t seg;
    bit       typed;  // expected box given in the row itself
    box_t     box;
  } row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [8*CW-1:0]     s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [4*CW-1:0]     m_tdata;

  box_t  pending_boxes[$];
  int    mismatches;
  int    snd_idle_pct;
  int    rcv_idle_pct;
  bit    hold_req;
  bit    finishing;
  int    quiet_cycles;
  row_t  rows[N_ROWS];

  cubic_bezier_bounding_box i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Box model. Everything is carried in wide integers so no step can overflow.
  // ---------------------------------------------------------------------------

  // x + floor((y - x) * t / 2^30), t in unsigned Q1.30.
  function automatic longint casteljau_mix(longint x, longint y, longint t);
    logic signed [127:0] dl;
    logic signed [127:0] tt;
    logic signed [127:0] pr;
    dl = y - x;
    tt = t;
    pr = dl * tt;
    return x + longint'(pr >>> T_FRAC);
  endfunction

  function automatic longint curve_value(longint a, longint b, longint c, longint d,
                                         longint t);
    longint ab, bc, cd, abc, bcd;
    ab  = casteljau_mix(a, b, t);
    bc  = casteljau_mix(b, c, t);
    cd  = casteljau_mix(c, d, t);
    abc = casteljau_mix(ab, bc, t);
    bcd = casteljau_mix(bc, cd, t);
    return casteljau_mix(abc, bcd, t);
  endfunction

  // Widen [lo, hi] by the extrema of one axis, if the derivative has roots in [0,1].
  function automatic void widen_by_extrema(input longint a, input longint b,
                                           input longint c, input longint d,
                                           inout longint lo, inout longint hi);
    longint p, q, r, den, tl, s, num, dd, t, rem, v;
    logic signed [127:0] disc;
    logic [127:0]        sq;
    logic [63:0]         root, cand;
    p   = b - a;
    q   = c - b;
    r   = d - c;
    den = p - 2 * q + r;
    tl  = p - q;
    // A zero denominator covers the quadratic-degenerate segments too.
    if (den == 0) return;
    disc = (128'(signed'(q)) * 128'(signed'(q))) - (128'(signed'(p)) * 128'(signed'(r)));
    // Negative discriminant: the derivative has no real root.
    if (disc < 0) return;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= 128'(disc)) root = cand;
    end
    s = longint'(root);
    for (int k = 0; k < 2; k++) begin
      num = (k != 0) ? tl + s : tl - s;
      dd  = den;
      if (dd < 0) begin
        num = -num;
        dd  = -dd;
      end
      // Roots outside [0,1] do not lie on the segment.
      if (num < 0 || num > dd) continue;
      if (num == dd) begin
        t = longint'(1) << T_FRAC;
      end else begin
        t   = 0;
        rem = num;
        for (int i = 0; i < T_FRAC; i++) begin
          rem = rem << 1;
          t   = t << 1;
          if (rem >= dd) begin
            rem = rem - dd;
            t   = t | 1;
          end
        end
      end
      v = curve_value(a, b, c, d, t);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
  endfunction

  // Values never leave the input range, but clamp to the coordinate range anyway.
  function automatic coord_t clamp_coord(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  function automatic box_t tight_box(segment_t sg);
    box_t   bx;
    longint lo[2], hi[2];
    longint e0, e3;
    for (int ax = 0; ax < 2; ax++) begin
      e0 = sg.pt[ax];
      e3 = sg.pt[6 + ax];
      lo[ax] = (e0 < e3) ? e0 : e3;
      hi[ax] = (e0 < e3) ? e3 : e0;
      widen_by_extrema(sg.pt[ax], sg.pt[2 + ax], sg.pt[4 + ax], e3, lo[ax], hi[ax]);
    end
    bx.xmin = clamp_coord(lo[0]);
    bx.xmax = clamp_coord(hi[0]);
    bx.ymin = clamp_coord(lo[1]);
    bx.ymax = clamp_coord(hi[1]);
    return bx;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic segment_t make_seg(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                        coord_t x2, coord_t y2, coord_t x3, coord_t y3);
    segment_t sg;
    sg.pt = '{x0, y0, x1, y1, x2, y2, x3, y3};
    return sg;
  endfunction

  function automatic box_t make_box(coord_t x0, coord_t x1, coord_t y0, coord_t y1);
    box_t bx;
    bx.xmin = x0;
    bx.xmax = x1;
    bx.ymin = y0;
    bx.ymax = y1;
    return bx;
  endfunction

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(0, 2 * 1048576)) - 1048576);
      2:       return ($urandom_range(0, 1) != 0)
                      ? coord_t'(32'h7fffffff - $urandom_range(0, 65535))
                      : coord_t'(32'h80000000 + $urandom_range(0, 65535));
      default: return coord_t'(int'($urandom_range(0, 2 * 4096)) - 4096);
    endcase
  endfunction

  function automatic segment_t random_seg();
    segment_t sg;
    int       kind;
    int       shape;
    kind  = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) sg.pt[i] = rand_coord(kind);
    if (shape == 0) begin
      // Control points on the end points on x: the x derivative roots sit at 0 and 1.
      sg.pt[2] = sg.pt[0];
      sg.pt[4] = sg.pt[6];
    end else if (shape == 1) begin
      // Evenly spaced points on x: zero quadratic term.
      sg.pt[2] = sg.pt[0] + (sg.pt[0] >>> 8);
      sg.pt[4] = sg.pt[2] + (sg.pt[0] >>> 8);
      sg.pt[6] = sg.pt[4] + (sg.pt[0] >>> 8);
    end else if (shape == 2) begin
      sg.pt[3] = sg.pt[1];
      sg.pt[5] = sg.pt[1];
      sg.pt[7] = sg.pt[1];
    end
    return sg;
  endfunction

  task automatic report_mismatch(string field, coord_t got, coord_t want);
    $display("mismatch %s: got %0d want %0d", field, got, want);
    mismatches++;
  endtask

  // Offer one beat and hold it until the block takes it.
  task automatic send_segment(segment_t sg, box_t bx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 8; i++) s_tdata[i*CW +: CW] <= sg.pt[i];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_boxes.push_back(bx);
    @(negedge clk);
  endtask

  // Sender pause until every expected box is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
  endtask

  task automatic fill_rows();
    coord_t mx, mn, u;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    u  = 32'sh00010000;
    rows[0]  = '{make_seg(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, make_box(0, 0, 0, 0)};
    rows[1]  = '{make_seg(mx, mx, mx, mx, mx, mx, mx, mx), 1'b1, make_box(mx, mx, mx, mx)};
    rows[2]  = '{make_seg(mn, mn, mn, mn, mn, mn, mn, mn), 1'b1, make_box(mn, mn, mn, mn)};
    // Straight, evenly spaced: the denominator is zero on both axes.
    rows[3]  = '{make_seg(0, 0, u, 2*u, 2*u, 4*u, 3*u, 6*u), 1'b1,
                 make_box(0, 3*u, 0, 6*u)};
    // Monotone with p*r > q*q: negative discriminant on both axes.
    rows[4]  = '{make_seg(0, 0, 10*u, 10*u, 11*u, 11*u, 21*u, 21*u), 1'b1,
                 make_box(0, 21*u, 0, 21*u)};
    rows[5]  = '{make_seg(mn, mx, mn, mx, mx, mn, mx, mn), 1'b0, '{default: 0}};
    rows[6]  = '{make_seg(mn, mn, mx, mx, mn, mn, mx, mx), 1'b0, '{default: 0}};
    rows[7]  = '{make_seg(0, 0, mx, mn, mn, mx, 0, 0), 1'b0, '{default: 0}};
    rows[8]  = '{make_seg(0, 0, 4*u, -4*u, 4*u, -4*u, 0, 0), 1'b0, '{default: 0}};
    // Roots outside the segment.
    rows[9]  = '{make_seg(0, 0, u, u, 3*u, 3*u, 4*u, 8*u), 1'b0, '{default: 0}};
    rows[10] = '{make_seg(-u, u, 5*u, -7*u, -3*u, 9*u, 2*u, -u), 1'b0, '{default: 0}};
    rows[11] = '{make_seg(mx, mn, 0, 0, 0, 0, mn, mx), 1'b0, '{default: 0}};
  endtask

  // ---------------------------------------------------------------------------
  // Sender: directed rows, then three random phases with different idling.
  // ---------------------------------------------------------------------------
  initial begin
    segment_t sg;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    mismatches   = 0;
    snd_idle_pct = 34;
    rcv_idle_pct = 82;
    hold_req     = 1'b0;
    finishing    = 1'b0;
    fill_rows();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_segment(rows[i].seg, rows[i].typed ? rows[i].box : tight_box(rows[i].seg));
    end

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        snd_idle_pct = 82;
        rcv_idle_pct = 34;
      end else if (ph == 2) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // The receiver holds off while beats keep coming, so the pipe fills.
        hold_req = 1'b1;
      end
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        sg = random_seg();
        send_segment(sg, tight_box(sg));
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    finishing = 1'b1;
    if (mismatches == 0 && pending_boxes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Output check: each box beat against the oldest expected box.
  always @(posedge clk) begin
    box_t want;
    box_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.xmin = m_tdata[0*CW +: CW];
      got.xmax = m_tdata[1*CW +: CW];
      got.ymin = m_tdata[2*CW +: CW];
      got.ymax = m_tdata[3*CW +: CW];
      if (pending_boxes.size() == 0) begin
        report_mismatch("box_xmin of a beat with none expected", got.xmin, '0);
      end else begin
        want = pending_boxes.pop_front();
        if (got.xmin !== want.xmin) report_mismatch("box_xmin", got.xmin, want.xmin);
        if (got.xmax !== want.xmax) report_mismatch("box_xmax", got.xmax, want.xmax);
        if (got.ymin !== want.ymin) report_mismatch("box_ymin", got.ymin, want.ymin);
        if (got.ymax !== want.ymax) report_mismatch("box_ymax", got.ymax, want.ymax);
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst || finishing || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ cubic_bezier_bounding_box.f @@
+incdir+rtl
rtl/cbb_pkg.sv
rtl/cubic_bezier_bounding_box.sv
tb/tb_top.sv
